// ===== src/piecewise_linear_table_interp_core_macros.svh =====
// assertion helpers shared by the checker
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PLIT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plit: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PLIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plit: next-cycle check failed");

`endif

// ===== src/plit_pkg.sv =====
package plit_pkg;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // fraction divide: one quotient bit per step, t has 17 bits
  localparam int unsigned DIV_LAST = 16;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_LOW    = 3'd1,
    ST_HIGH   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_NOBR   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_EMPTY    = 3'd2,
    C_X_LE_A   = 3'd3,
    C_X_GE_B   = 3'd4,
    C_BRACKET  = 3'd5,
    C_DX_ZERO  = 3'd6,
    C_OUT_BUSY = 3'd7
  } cond_e;

  typedef enum logic [1:0] {
    LP_NONE = 2'd0,
    LP_SCAN = 2'd1,
    LP_DIV  = 2'd2
  } loop_e;

  typedef enum logic [1:0] {
    RA_NONE = 2'd0,
    RA_ZERO = 2'd1,
    RA_LAST = 2'd2,
    RA_IDX  = 2'd3
  } raddr_e;

  typedef enum logic [1:0] {
    IX_HOLD = 2'd0,
    IX_ONE  = 2'd1,
    IX_CLR  = 2'd2,
    IX_INC  = 2'd3
  } idx_e;

  typedef enum logic [3:0] {
    DP_NONE     = 4'd0,
    DP_DIV_INIT = 4'd1,
    DP_DIV_STEP = 4'd2,
    DP_MUL      = 4'd3,
    DP_SHIFT    = 4'd4,
    DP_SUM      = 4'd5,
    DP_RES_ZERO = 4'd6,
    DP_RES_A    = 4'd7,
    DP_RES_B    = 4'd8
  } dp_e;

  // program step addresses
  localparam logic [3:0] S_START      = 4'd0;
  localparam logic [3:0] S_LOAD_A     = 4'd1;
  localparam logic [3:0] S_LOAD_B     = 4'd2;
  localparam logic [3:0] S_TEST_HI    = 4'd3;
  localparam logic [3:0] S_SCAN       = 4'd4;
  localparam logic [3:0] S_NO_BRACKET = 4'd5;
  localparam logic [3:0] S_EMPTY      = 4'd6;
  localparam logic [3:0] S_CLAMP_LO   = 4'd7;
  localparam logic [3:0] S_CLAMP_HI   = 4'd8;
  localparam logic [3:0] S_FOUND      = 4'd9;
  localparam logic [3:0] S_DIV        = 4'd10;
  localparam logic [3:0] S_MUL        = 4'd11;
  localparam logic [3:0] S_SHIFT      = 4'd12;
  localparam logic [3:0] S_SUM        = 4'd13;
  localparam logic [3:0] S_ZERO_W     = 4'd14;
  localparam logic [3:0] S_EMIT       = 4'd15;

  typedef struct packed {
    cond_e      cond;
    logic [3:0] target;
    loop_e      loop;
    raddr_e     raddr;
    idx_e       idx_op;
    logic       load_a;
    logic       load_b;
    logic       shift_a;
    dp_e        op;
    status_e    status;
    logic       emit;
    logic       last;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t word;
    logic       taken;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic x_le_a;
    logic x_ge_b;
    logic bracket;
    logic dx_zero;
    logic scan_more;
    logic div_more;
  } flags_t;

  localparam ctrl_word_t UW_NOP = '{
    cond: C_NONE, target: S_START, loop: LP_NONE, raddr: RA_NONE, idx_op: IX_HOLD,
    load_a: 1'b0, load_b: 1'b0, shift_a: 1'b0, op: DP_NONE, status: ST_INTERP,
    emit: 1'b0, last: 1'b0
  };

  // control store
  function automatic ctrl_word_t ucode(logic [3:0] pc);
    ctrl_word_t w;
    w = UW_NOP;
    unique case (pc)
      S_START: begin
        w.cond = C_EMPTY; w.target = S_EMPTY;
        w.raddr = RA_ZERO; w.idx_op = IX_ONE;
      end
      S_LOAD_A: begin
        w.load_a = 1'b1; w.raddr = RA_LAST;
      end
      S_LOAD_B: begin
        w.load_b = 1'b1; w.cond = C_X_LE_A; w.target = S_CLAMP_LO;
      end
      S_TEST_HI: begin
        w.cond = C_X_GE_B; w.target = S_CLAMP_HI;
        w.raddr = RA_IDX; w.idx_op = IX_INC;
      end
      S_SCAN: begin
        w.load_b = 1'b1; w.shift_a = 1'b1; w.raddr = RA_IDX; w.idx_op = IX_INC;
        w.cond = C_BRACKET; w.target = S_FOUND; w.loop = LP_SCAN;
      end
      S_NO_BRACKET: begin
        w.op = DP_RES_B; w.status = ST_NOBR; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_EMPTY: begin
        w.op = DP_RES_ZERO; w.status = ST_EMPTY; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_CLAMP_LO: begin
        w.op = DP_RES_A; w.status = ST_LOW; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_CLAMP_HI: begin
        w.op = DP_RES_B; w.status = ST_HIGH; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_FOUND: begin
        w.op = DP_DIV_INIT; w.idx_op = IX_CLR; w.cond = C_DX_ZERO; w.target = S_ZERO_W;
      end
      S_DIV: begin
        w.op = DP_DIV_STEP; w.idx_op = IX_INC; w.loop = LP_DIV;
      end
      S_MUL: begin
        w.op = DP_MUL;
      end
      S_SHIFT: begin
        w.op = DP_SHIFT;
      end
      S_SUM: begin
        w.op = DP_SUM; w.status = ST_INTERP; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_ZERO_W: begin
        w.op = DP_RES_A; w.status = ST_INTERP;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.cond = C_OUT_BUSY; w.target = S_EMIT; w.last = 1'b1;
      end
      default: begin
        w = UW_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/plit_req_if.sv =====
interface plit_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic        [5:0]  point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;

  modport source (output valid, req_type, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink   (input valid, req_type, point_index, point_x, point_y, query_x,
                  output ready);
endinterface

// ===== src/plit_res_if.sv =====
interface plit_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_y;
  logic        [2:0]  status;

  modport source (output valid, result_y, status, input ready);
  modport sink   (input valid, result_y, status, output ready);
endinterface

// ===== src/plit_ram.sv =====
module plit_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/plit_seq.sv =====
module plit_seq import plit_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  flags_t flags_i,
  input  logic   out_busy_i,
  output ctrl_t  ctrl_o,
  output logic   busy_o
);

  logic       run_q, run_d;
  logic [3:0] pc_q, pc_d;
  ctrl_word_t word;
  logic       cond_true;
  logic       stay;
  logic       taken;

  always_comb begin
    word = run_q ? ucode(pc_q) : UW_NOP;
  end

  always_comb begin
    unique case (word.cond)
      C_NONE:     cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_EMPTY:    cond_true = flags_i.empty;
      C_X_LE_A:   cond_true = flags_i.x_le_a;
      C_X_GE_B:   cond_true = flags_i.x_ge_b;
      C_BRACKET:  cond_true = flags_i.bracket;
      C_DX_ZERO:  cond_true = flags_i.dx_zero;
      C_OUT_BUSY: cond_true = out_busy_i;
      default:    cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.loop)
      LP_SCAN: stay = flags_i.scan_more;
      LP_DIV:  stay = flags_i.div_more;
      default: stay = 1'b0;
    endcase
  end

  assign taken = run_q & cond_true;

  always_comb begin
    run_d = run_q;
    pc_d  = pc_q;
    if (start_i) begin
      run_d = 1'b1;
      pc_d  = S_START;
    end else if (run_q) begin
      if (taken) begin
        pc_d = word.target;
      end else if (stay) begin
        pc_d = pc_q;
      end else if (word.last) begin
        run_d = 1'b0;
      end else begin
        pc_d = pc_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      pc_q  <= S_START;
    end else begin
      run_q <= run_d;
      pc_q  <= pc_d;
    end
  end

  assign ctrl_o.word  = word;
  assign ctrl_o.taken = taken;
  assign busy_o       = run_q;

endmodule

// ===== src/plit_dp.sv =====
module plit_dp import plit_pkg::*; #(
  parameter int unsigned POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] query_x_i,
  input  logic               wr_en_i,
  input  logic        [5:0]  wr_index_i,
  input  logic signed [31:0] wr_x_i,
  input  logic signed [31:0] wr_y_i,
  input  logic        [6:0]  point_count_i,
  input  ctrl_t              ctrl_i,
  output flags_t             flags_o,
  output logic signed [31:0] result_y_o,
  output status_e            status_o
);

  localparam int unsigned AW  = $clog2(POINTS);
  localparam int unsigned CW0 = $clog2(POINTS + 1);
  localparam int unsigned CW  = (CW0 > 7) ? CW0 : 7;

  ctrl_word_t w;
  assign w = ctrl_i.word;

  // clamp the count to the table size
  logic [CW-1:0] cnt_ext, n, n_m1;
  assign cnt_ext = CW'(point_count_i);
  assign n       = (cnt_ext > CW'(POINTS)) ? CW'(POINTS) : cnt_ext;
  assign n_m1    = n - CW'(1);

  logic [CW-1:0] idx_q, idx_d;

  // table ram, x in the upper half
  logic          wr_ok;
  logic          re;
  logic [AW-1:0] raddr;
  logic [63:0]   rdata;
  logic signed [31:0] rd_x, rd_y;

  assign wr_ok = wr_en_i && (32'(wr_index_i) < POINTS);

  always_comb begin
    unique case (w.raddr)
      RA_ZERO: raddr = '0;
      RA_LAST: raddr = n_m1[AW-1:0];
      RA_IDX:  raddr = idx_q[AW-1:0];
      default: raddr = '0;
    endcase
  end
  assign re = (w.raddr != RA_NONE);

  plit_ram #(.WIDTH(64), .DEPTH(POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (AW'(wr_index_i)),
    .wdata_i ({wr_x_i, wr_y_i}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[63:32];
  assign rd_y = rdata[31:0];

  logic signed [31:0] qx_q, xa_q, ya_q, xb_q, yb_q;
  logic               load_a;
  assign load_a = w.load_a | (w.shift_a & ~ctrl_i.taken);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qx_q <= query_x_i;
    end
    if (load_a) begin
      xa_q <= rd_x;
      ya_q <= rd_y;
    end
    if (w.load_b) begin
      xb_q <= rd_x;
      yb_q <= rd_y;
    end
  end

  always_comb begin
    unique case (w.idx_op)
      IX_ONE:  idx_d = CW'(1);
      IX_CLR:  idx_d = '0;
      IX_INC:  idx_d = idx_q + CW'(1);
      default: idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // fraction divide, multiply, rounding toward zero, saturating add
  logic signed [32:0] num_diff, den_diff, dy;
  logic        [32:0] rem_q, rem_d, rem_sub;
  logic        [31:0] den_q, den_d;
  logic        [16:0] quo_q, quo_d;
  logic               ge;
  logic signed [50:0] prod_q, prod_d, biased;
  logic signed [34:0] frac_q, frac_d;
  logic signed [35:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] result_q, result_d;
  status_e            status_q, status_d;

  assign num_diff = {qx_q[31], qx_q} - {xa_q[31], xa_q};
  assign den_diff = {xb_q[31], xb_q} - {xa_q[31], xa_q};
  assign dy       = {yb_q[31], yb_q} - {ya_q[31], ya_q};
  assign ge       = (rem_q >= {1'b0, den_q});
  assign rem_sub  = ge ? (rem_q - {1'b0, den_q}) : rem_q;
  assign biased   = prod_q + (prod_q[50] ? 51'sd65535 : 51'sd0);
  assign sum      = {{4{ya_q[31]}}, ya_q} + {frac_q[34], frac_q};

  always_comb begin
    if (!sum[35] && (|sum[34:31])) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum[35] && !(&sum[34:31])) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_comb begin
    rem_d    = rem_q;
    den_d    = den_q;
    quo_d    = quo_q;
    prod_d   = prod_q;
    frac_d   = frac_q;
    result_d = result_q;
    status_d = status_q;
    case (w.op)
      DP_DIV_INIT: begin
        rem_d = {1'b0, num_diff[31:0]};
        den_d = den_diff[31:0];
        quo_d = '0;
      end
      DP_DIV_STEP: begin
        quo_d = {quo_q[15:0], ge};
        rem_d = {rem_sub[31:0], 1'b0};
      end
      DP_MUL:   prod_d = $signed({1'b0, quo_q}) * dy;
      DP_SHIFT: frac_d = biased[50:16];
      DP_SUM: begin
        result_d = sat;
        status_d = w.status;
      end
      DP_RES_ZERO: begin
        result_d = '0;
        status_d = w.status;
      end
      DP_RES_A: begin
        result_d = ya_q;
        status_d = w.status;
      end
      DP_RES_B: begin
        result_d = yb_q;
        status_d = w.status;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    den_q    <= den_d;
    quo_q    <= quo_d;
    prod_q   <= prod_d;
    frac_q   <= frac_d;
    result_q <= result_d;
    status_q <= status_d;
  end

  assign flags_o.empty     = (n == '0);
  assign flags_o.x_le_a    = (qx_q <= xa_q);
  assign flags_o.x_ge_b    = (qx_q >= xb_q);
  assign flags_o.bracket   = (qx_q >= xa_q) && (qx_q <= rd_x);
  assign flags_o.dx_zero   = (xa_q == xb_q);
  assign flags_o.scan_more = (idx_q != n);
  assign flags_o.div_more  = (idx_q != CW'(DIV_LAST));

  assign result_y_o = result_q;
  assign status_o   = status_q;

endmodule

// ===== src/piecewise_linear_table_interp_core.sv =====
// a write lands in its own beat and gives no result; a query runs the start, load and clamp
//   test steps and the scan for a bracket, then gives an empty, clamp, no-bracket or zero-width
//   result or runs the divide, multiply, shift and sum steps, and ends in the emit step
// flow: one query at a time, next beat taken in the cycle after the result loads, a held
//   result stalls the emit step; writes go back to back while no query runs
// reset: async active low, clears point_count, sequencer and output valid; table undefined
module piecewise_linear_table_interp_core import plit_pkg::*; #(
  parameter int unsigned POINTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plit_req_if.sink   req_i,
  plit_res_if.source res_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  // control between sequencer and datapath
  ctrl_t   ctrl;
  flags_t  flags;
  logic    busy;
  logic    req_beat;
  logic    start;
  logic    wr_en;
  logic    out_busy;
  logic    out_load;

  logic signed [31:0] dp_result;
  status_e            dp_status;

  // breakpoint count register
  logic [6:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // a new beat is taken whenever no query program is running;
  // a waiting result in the output register does not block writes
  assign req_i.ready = ~busy;
  assign req_beat    = req_i.valid & req_i.ready;
  assign start       = req_beat & (req_i.req_type == REQ_QUERY);
  assign wr_en       = req_beat & (req_i.req_type == REQ_WRITE);

  plit_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .flags_i    (flags),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  plit_dp #(.POINTS(POINTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .query_x_i     (req_i.query_x),
    .wr_en_i       (wr_en),
    .wr_index_i    (req_i.point_index),
    .wr_x_i        (req_i.point_x),
    .wr_y_i        (req_i.point_y),
    .point_count_i (count_q),
    .ctrl_i        (ctrl),
    .flags_o       (flags),
    .result_y_o    (dp_result),
    .status_o      (dp_status)
  );

  // output register; the emit step spins while an older result is still held
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_y_q;
  logic        [2:0]  out_st_q;

  assign out_busy = out_valid_q & ~res_o.ready;
  assign out_load = ctrl.word.emit & ~ctrl.taken;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_y_q  <= dp_result;
      out_st_q <= dp_status;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.result_y = out_y_q;
  assign res_o.status   = out_st_q;

endmodule

// ===== src/plit_checker.sv =====
`include "piecewise_linear_table_interp_core_macros.svh"

module plit_checker import plit_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        req_type_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] res_result_y_i,
  input logic [2:0]  res_status_i
);

  // result beat held until taken
  `PLIT_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i)
  `PLIT_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i, $stable(res_result_y_i) && $stable(res_status_i))

  // a query occupies the block, a write does not
  `PLIT_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, req_valid_i && req_ready_i && (req_type_i == REQ_QUERY), !req_ready_i)
  `PLIT_ASSERT_NEXT(a_write_free, clk_i, rst_ni, req_valid_i && req_ready_i && (req_type_i == REQ_WRITE), req_ready_i)

  // only defined status codes leave the block
  `PLIT_ASSERT_SAME(a_status_code, clk_i, rst_ni, res_valid_i, res_status_i <= ST_NOBR)

endmodule

bind piecewise_linear_table_interp_core plit_checker u_plit_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_type_i     (req_i.req_type),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_result_y_i (res_o.result_y),
  .res_status_i   (res_o.status)
);
